// File: hw/rtl/cpca_pkg.sv
package cpca_pkg;

  localparam int NUM_CHANNELS = 8;

  localparam int CHANNEL_W = 3;
  localparam int CH_IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CH_CMP_W  = ($clog2(NUM_CHANNELS + 1) > CHANNEL_W) ?
                             $clog2(NUM_CHANNELS + 1) : CHANNEL_W;

  localparam int PR_W    = 36;
  localparam int PH_IN_W = 48;
  localparam int RATE_W  = 32;
  localparam int TIME_W  = 44;
  localparam int COUNT_W = 8;
  localparam int PHASE_W = 56;

  localparam int A_W   = 96;
  localparam int B_W   = 64;
  localparam int DIG_W = 32;
  localparam int PROD_W = 2 * DIG_W;
  localparam int ACC_W = 128;
  localparam int MAG_W = RATE_W + TIME_W + 1;

  localparam int SEED_SHIFT  = 24;
  localparam int DRIFT_SHIFT = 56;

  // L1 over c, unsigned Q3.32 cycles per metre
  localparam logic [B_W-1:0] LPC = 64'd22570205477;

  localparam logic [ACC_W-1:0] RND_SEED  = ACC_W'(1) << (SEED_SHIFT - 1);
  localparam logic [ACC_W-1:0] RND_DRIFT = ACC_W'(1) << (DRIFT_SHIFT - 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX          = 8'd255;
  localparam logic [COUNT_W-1:0] SEED_COUNT_FREE    = 8'd1;
  localparam logic [COUNT_W-1:0] SEED_COUNT_STEERED = 8'd3;

  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_LAST = 5'd23;

  localparam logic [1:0] MAC_NOP  = 2'd0;
  localparam logic [1:0] MAC_MUL  = 2'd1;
  localparam logic [1:0] MAC_ADDC = 2'd2;
  localparam logic [1:0] MAC_NEG  = 2'd3;

  localparam logic [1:0] A_RAW = 2'd0;
  localparam logic [1:0] A_COR = 2'd1;
  localparam logic [1:0] A_DT  = 2'd2;
  localparam logic [1:0] A_MAG = 2'd3;

  localparam logic B_LPC  = 1'b0;
  localparam logic B_RATE = 1'b1;

  localparam logic [1:0] CAP_NONE     = 2'd0;
  localparam logic [1:0] CAP_SEED_RAW = 2'd1;
  localparam logic [1:0] CAP_SEED_COR = 2'd2;
  localparam logic [1:0] CAP_MAG      = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] a_sel;
    logic       b_sel;
    logic [1:0] sh;
    logic       clr;
    logic       rnd_hi;
  } mac_op_t;

  typedef struct packed {
    mac_op_t    op;
    logic [1:0] a_src;
    logic       b_src;
    logic [1:0] cap;
  } prog_t;

  typedef struct packed {
    logic [COUNT_W-1:0] cnt;
    logic [PHASE_W-1:0] raw;
    logic [PHASE_W-1:0] cor;
  } chan_state_t;

  function automatic mac_op_t mul_op(input logic [1:0] a_sel, input logic b_sel,
                                     input logic [1:0] sh, input logic clr);
    mac_op_t o;
    o        = '0;
    o.kind   = MAC_MUL;
    o.a_sel  = a_sel;
    o.b_sel  = b_sel;
    o.sh     = sh;
    o.clr    = clr;
    return o;
  endfunction

  // micro-program: seed(raw), seed(corr), |rate*dt|, |rate*dt|*LPC, sign, round
  function automatic prog_t prog_entry(input logic [STEP_W-1:0] step);
    prog_t e;
    e = '0;
    case (step)
      5'd0:  begin e.op = mul_op(2'd0, 1'b0, 2'd0, 1'b1); e.a_src = A_RAW; end
      5'd1:  begin e.op = mul_op(2'd0, 1'b1, 2'd1, 1'b0); e.a_src = A_RAW; end
      5'd2:  begin e.op = mul_op(2'd1, 1'b0, 2'd1, 1'b0); e.a_src = A_RAW; end
      5'd3:  begin e.op = mul_op(2'd1, 1'b1, 2'd2, 1'b0); e.a_src = A_RAW; end
      5'd4:  begin e.op.kind = MAC_ADDC; end
      5'd5:  begin e.op = mul_op(2'd0, 1'b0, 2'd0, 1'b1); e.a_src = A_COR; end
      5'd6:  begin
        e.op = mul_op(2'd0, 1'b1, 2'd1, 1'b0); e.a_src = A_COR; e.cap = CAP_SEED_RAW;
      end
      5'd7:  begin e.op = mul_op(2'd1, 1'b0, 2'd1, 1'b0); e.a_src = A_COR; end
      5'd8:  begin e.op = mul_op(2'd1, 1'b1, 2'd2, 1'b0); e.a_src = A_COR; end
      5'd9:  begin e.op.kind = MAC_ADDC; end
      5'd10: begin
        e.op = mul_op(2'd0, 1'b0, 2'd0, 1'b1); e.a_src = A_DT; e.b_src = B_RATE;
      end
      5'd11: begin
        e.op = mul_op(2'd1, 1'b0, 2'd1, 1'b0); e.a_src = A_DT; e.b_src = B_RATE;
        e.cap = CAP_SEED_COR;
      end
      5'd13: begin e.cap = CAP_MAG; end
      5'd14: begin e.op = mul_op(2'd0, 1'b0, 2'd0, 1'b1); e.a_src = A_MAG; end
      5'd15: begin e.op = mul_op(2'd0, 1'b1, 2'd1, 1'b0); e.a_src = A_MAG; end
      5'd16: begin e.op = mul_op(2'd1, 1'b0, 2'd1, 1'b0); e.a_src = A_MAG; end
      5'd17: begin e.op = mul_op(2'd1, 1'b1, 2'd2, 1'b0); e.a_src = A_MAG; end
      5'd18: begin e.op = mul_op(2'd2, 1'b0, 2'd2, 1'b0); e.a_src = A_MAG; end
      5'd19: begin e.op = mul_op(2'd2, 1'b1, 2'd3, 1'b0); e.a_src = A_MAG; end
      5'd20: begin e.op.kind = MAC_NEG; end
      5'd21: begin e.op.kind = MAC_ADDC; e.op.rnd_hi = 1'b1; end
      default: begin e = '0; end
    endcase
    return e;
  endfunction

endpackage

// File: hw/rtl/cpca_if.sv
interface cpca_in_if;
  logic                                valid;
  logic                                ready;
  logic [cpca_pkg::CHANNEL_W-1:0]      channel;
  logic                                measurement_valid;
  logic [cpca_pkg::PR_W-1:0]           raw_pseudorange;
  logic [cpca_pkg::PR_W-1:0]           corrected_pseudorange;
  logic signed [cpca_pkg::PH_IN_W-1:0] phase_now;
  logic signed [cpca_pkg::PH_IN_W-1:0] phase_prev;
  logic signed [cpca_pkg::RATE_W-1:0]  clock_drift_rate;
  logic [cpca_pkg::TIME_W-1:0]         rx_time_now;
  logic [cpca_pkg::TIME_W-1:0]         rx_time_prev;

  modport source (output valid, channel, measurement_valid, raw_pseudorange,
                  corrected_pseudorange, phase_now, phase_prev, clock_drift_rate,
                  rx_time_now, rx_time_prev, input ready);
  modport sink   (input valid, channel, measurement_valid, raw_pseudorange,
                  corrected_pseudorange, phase_now, phase_prev, clock_drift_rate,
                  rx_time_now, rx_time_prev, output ready);
endinterface

interface cpca_out_if;
  logic                                valid;
  logic                                ready;
  logic [cpca_pkg::CHANNEL_W-1:0]      out_channel;
  logic [cpca_pkg::COUNT_W-1:0]        lock_count;
  logic signed [cpca_pkg::PHASE_W-1:0] raw_carrier_phase;
  logic signed [cpca_pkg::PHASE_W-1:0] corrected_carrier_phase;

  modport source (output valid, out_channel, lock_count, raw_carrier_phase,
                  corrected_carrier_phase, input ready);
  modport sink   (input valid, out_channel, lock_count, raw_carrier_phase,
                  corrected_carrier_phase, output ready);
endinterface

interface cpca_cfg_if;
  logic valid;
  logic ready;
  logic clock_steering;

  modport source (output valid, clock_steering, input ready);
  modport sink   (input valid, clock_steering, output ready);
endinterface

// File: hw/rtl/carrier_phase_correction_accumulator.sv
// Clock-corrected carrier phase accumulator for up to NUM_CHANNELS tracking channels.
// Each input transaction is one epoch of one channel; one result transaction follows
// with that channel's lock count and raw and corrected phases after the update.
// The result register is loaded at the end of a 24-step sequence that starts at the edge
// that accepts a transaction; that edge also reads the channel state. The steps run through
// a single shared 32x32 multiply-accumulate unit (both pseudorange seeds, the drift
// product and its rounding). The next transaction can be accepted in the cycle after
// the result is registered, so no new transaction is taken during a sequence, and the
// last step holds while the result waits to be taken. Channel state is zero after reset
// with no clearing pass. clock_steering is written through cfg_chan, which is always
// ready; the user must write it only while the block is idle, the block does not check.
module carrier_phase_correction_accumulator (
  input  logic         clk,
  input  logic         rst_n,
  cpca_in_if.sink      in_chan,
  cpca_out_if.source   out_chan,
  cpca_cfg_if.sink     cfg_chan
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic                                state_r;
  logic [cpca_pkg::STEP_W-1:0]         step_r;
  logic                                steer_r;

  logic [cpca_pkg::CHANNEL_W-1:0]      chan_r;
  logic                                mval_r;
  logic [cpca_pkg::PR_W-1:0]           raw_pr_r;
  logic [cpca_pkg::PR_W-1:0]           cor_pr_r;
  logic [cpca_pkg::PHASE_W-1:0]        delta_r;
  logic [cpca_pkg::TIME_W-1:0]         dt_mag_r;
  logic [cpca_pkg::RATE_W-1:0]         rate_mag_r;
  logic                                neg_r;
  logic [cpca_pkg::PHASE_W-1:0]        seed_raw_r;
  logic [cpca_pkg::PHASE_W-1:0]        seed_cor_r;
  logic [cpca_pkg::MAG_W-1:0]          mag_r;

  logic                                out_vld_r;
  logic [cpca_pkg::CHANNEL_W-1:0]      out_chan_r;
  logic [cpca_pkg::COUNT_W-1:0]        out_lock_r;
  logic [cpca_pkg::PHASE_W-1:0]        out_raw_r;
  logic [cpca_pkg::PHASE_W-1:0]        out_cor_r;

  logic                                accept;
  logic                                fin;
  logic [cpca_pkg::TIME_W:0]           dt_full;
  logic [cpca_pkg::TIME_W:0]           dt_neg;
  logic [cpca_pkg::RATE_W-1:0]         rate_u;
  logic [cpca_pkg::CH_CMP_W-1:0]       in_ch_cmp;
  logic [cpca_pkg::CH_CMP_W-1:0]       ch_cmp;
  logic                                in_range;

  cpca_pkg::prog_t                     pe;
  cpca_pkg::mac_op_t                   mac_op;
  logic [cpca_pkg::A_W-1:0]            a_word;
  logic [cpca_pkg::B_W-1:0]            b_word;
  logic [cpca_pkg::ACC_W-1:0]          acc;
  logic [cpca_pkg::PHASE_W-1:0]        drift;

  cpca_pkg::chan_state_t               cur;
  cpca_pkg::chan_state_t               upd;
  logic [cpca_pkg::COUNT_W-1:0]        cnt_inc;

  assign accept         = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign fin = (state_r == ST_BUSY) && (step_r == cpca_pkg::STEP_LAST) &&
               (!out_vld_r || out_chan.ready);

  assign in_ch_cmp = cpca_pkg::CH_CMP_W'(in_chan.channel);
  assign ch_cmp    = cpca_pkg::CH_CMP_W'(chan_r);
  assign in_range  = (ch_cmp < cpca_pkg::CH_CMP_W'(cpca_pkg::NUM_CHANNELS));

  assign dt_full = {1'b0, in_chan.rx_time_now} - {1'b0, in_chan.rx_time_prev};
  assign dt_neg  = ~dt_full + {{cpca_pkg::TIME_W{1'b0}}, 1'b1};
  assign rate_u  = in_chan.clock_drift_rate;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_r <= 1'b0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      steer_r <= cfg_chan.clock_steering;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_BUSY;
            step_r  <= '0;
          end
        end
        ST_BUSY: begin
          if (step_r != cpca_pkg::STEP_LAST) begin
            step_r <= step_r + cpca_pkg::STEP_W'(1);
          end else if (fin) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      chan_r     <= in_chan.channel;
      mval_r     <= in_chan.measurement_valid;
      raw_pr_r   <= in_chan.raw_pseudorange;
      cor_pr_r   <= in_chan.corrected_pseudorange;
      delta_r    <= {{8{in_chan.phase_now[47]}}, in_chan.phase_now} -
                    {{8{in_chan.phase_prev[47]}}, in_chan.phase_prev};
      dt_mag_r   <= dt_full[cpca_pkg::TIME_W] ? dt_neg[cpca_pkg::TIME_W-1:0]
                                              : dt_full[cpca_pkg::TIME_W-1:0];
      rate_mag_r <= rate_u[cpca_pkg::RATE_W-1] ? (~rate_u + cpca_pkg::RATE_W'(1)) : rate_u;
      neg_r      <= rate_u[cpca_pkg::RATE_W-1] ^ dt_full[cpca_pkg::TIME_W];
    end
  end

  assign pe = cpca_pkg::prog_entry(step_r);

  always_comb begin
    mac_op = pe.op;
    if (state_r != ST_BUSY) begin
      mac_op = '0;
    end else if (pe.op.kind == cpca_pkg::MAC_NEG && !neg_r) begin
      mac_op.kind = cpca_pkg::MAC_NOP;
    end
    case (pe.a_src)
      cpca_pkg::A_RAW: a_word = {60'b0, raw_pr_r};
      cpca_pkg::A_COR: a_word = {60'b0, cor_pr_r};
      cpca_pkg::A_DT:  a_word = {52'b0, dt_mag_r};
      default:         a_word = {19'b0, mag_r};
    endcase
    b_word = (pe.b_src == cpca_pkg::B_RATE) ? {32'b0, rate_mag_r} : cpca_pkg::LPC;
  end

  cpca_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (mac_op),
    .a_word (a_word),
    .b_word (b_word),
    .acc    (acc)
  );

  always_ff @(posedge clk) begin
    if (state_r == ST_BUSY) begin
      case (pe.cap)
        cpca_pkg::CAP_SEED_RAW:
          seed_raw_r <= acc[cpca_pkg::SEED_SHIFT+cpca_pkg::PHASE_W-1:cpca_pkg::SEED_SHIFT];
        cpca_pkg::CAP_SEED_COR:
          seed_cor_r <= acc[cpca_pkg::SEED_SHIFT+cpca_pkg::PHASE_W-1:cpca_pkg::SEED_SHIFT];
        cpca_pkg::CAP_MAG:
          mag_r <= acc[cpca_pkg::MAG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign drift = acc[cpca_pkg::DRIFT_SHIFT+cpca_pkg::PHASE_W-1:cpca_pkg::DRIFT_SHIFT];

  cpca_state_mem u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_ch_cmp[cpca_pkg::CH_IDX_W-1:0]),
    .rd_data (cur),
    .wr_en   (fin && in_range),
    .wr_addr (ch_cmp[cpca_pkg::CH_IDX_W-1:0]),
    .wr_data (upd)
  );

  always_comb begin
    cnt_inc = (cur.cnt == cpca_pkg::COUNT_MAX) ? cur.cnt
                                               : cur.cnt + cpca_pkg::COUNT_W'(1);
    upd = cur;
    if (!mval_r) begin
      upd.cnt = '0;
    end else begin
      upd.cnt = cnt_inc;
      if (!steer_r) begin
        if (cnt_inc == cpca_pkg::SEED_COUNT_FREE) begin
          upd.raw = seed_raw_r;
          upd.cor = seed_cor_r;
        end else begin
          upd.raw = cur.raw + delta_r;
          upd.cor = cur.cor + delta_r - drift;
        end
      end else begin
        if (cnt_inc == cpca_pkg::SEED_COUNT_STEERED) begin
          upd.cor = seed_raw_r;
        end else if (cnt_inc > cpca_pkg::SEED_COUNT_STEERED) begin
          upd.cor = cur.cor + delta_r - drift;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fin) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_chan_r <= chan_r;
      out_lock_r <= in_range ? upd.cnt : '0;
      out_raw_r  <= in_range ? upd.raw : '0;
      out_cor_r  <= in_range ? upd.cor : '0;
    end
  end

  assign out_chan.valid                   = out_vld_r;
  assign out_chan.out_channel             = out_chan_r;
  assign out_chan.lock_count              = out_lock_r;
  assign out_chan.raw_carrier_phase       = out_raw_r;
  assign out_chan.corrected_carrier_phase = out_cor_r;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_BUSY && step_r == '0))
    else $error("sequence did not start on accepted transaction");

  a_out_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == ST_BUSY && step_r == cpca_pkg::STEP_LAST))
    else $error("result raised outside the last step");

  a_invalid_clears_lock: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_vld_r) && !mval_r) |-> (out_lock_r == '0))
    else $error("invalid measurement left a non-zero lock count");

  a_out_channel_match: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> (out_chan_r == chan_r))
    else $error("result channel differs from the transaction channel");
`endif

endmodule

// File: hw/rtl/cpca_mac.sv
module cpca_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cpca_pkg::mac_op_t             op,
  input  logic [cpca_pkg::A_W-1:0]      a_word,
  input  logic [cpca_pkg::B_W-1:0]      b_word,
  output logic [cpca_pkg::ACC_W-1:0]    acc
);

  logic [cpca_pkg::DIG_W-1:0]  a_dig;
  logic [cpca_pkg::DIG_W-1:0]  b_dig;
  logic [cpca_pkg::PROD_W-1:0] prod_r;
  cpca_pkg::mac_op_t           s1_r;
  logic [cpca_pkg::ACC_W-1:0]  acc_r;
  logic [cpca_pkg::ACC_W-1:0]  acc_nxt;
  logic [cpca_pkg::ACC_W-1:0]  shifted;
  logic [cpca_pkg::ACC_W-1:0]  base;

  always_comb begin
    case (op.a_sel)
      2'd0:    a_dig = a_word[31:0];
      2'd1:    a_dig = a_word[63:32];
      2'd2:    a_dig = a_word[95:64];
      default: a_dig = '0;
    endcase
    b_dig = op.b_sel ? b_word[63:32] : b_word[31:0];
  end

  always_ff @(posedge clk) begin
    prod_r <= a_dig * b_dig;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else begin
      s1_r <= op;
    end
  end

  always_comb begin
    case (s1_r.sh)
      2'd0:    shifted = {64'b0, prod_r};
      2'd1:    shifted = {32'b0, prod_r, 32'b0};
      2'd2:    shifted = {prod_r, 64'b0};
      default: shifted = {prod_r[31:0], 96'b0};
    endcase
    base = s1_r.clr ? '0 : acc_r;
    case (s1_r.kind)
      cpca_pkg::MAC_MUL:  acc_nxt = base + shifted;
      cpca_pkg::MAC_ADDC: acc_nxt = acc_r + (s1_r.rnd_hi ? cpca_pkg::RND_DRIFT
                                                         : cpca_pkg::RND_SEED);
      cpca_pkg::MAC_NEG:  acc_nxt = ~acc_r + cpca_pkg::ACC_W'(1);
      default:            acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// File: hw/rtl/cpca_state_mem.sv
module cpca_state_mem (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            rd_en,
  input  logic [cpca_pkg::CH_IDX_W-1:0]   rd_addr,
  output cpca_pkg::chan_state_t           rd_data,
  input  logic                            wr_en,
  input  logic [cpca_pkg::CH_IDX_W-1:0]   wr_addr,
  input  cpca_pkg::chan_state_t           wr_data
);

  cpca_pkg::chan_state_t                mem_r [cpca_pkg::NUM_CHANNELS];
  logic [cpca_pkg::NUM_CHANNELS-1:0]    vld_r;
  cpca_pkg::chan_state_t                rd_data_r;
  logic                                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // never-written entries read as zero
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// File: sim/cpca_checker.sv
`timescale 1ns / 1ps

module cpca_checker (
  input  logic clk,
  input  logic rst_n,
  cpca_in_if   in_mon,
  cpca_out_if  out_mon,
  cpca_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending_count,
  output int   checked_count
);
  import cpca_pkg::*;

  // L1 over c, unsigned Q3.32 cycles per metre
  localparam logic [63:0] L1_PER_C = 64'd22570205477;

  typedef struct packed {
    logic [CHANNEL_W-1:0] ch;
    logic [COUNT_W-1:0]   cnt;
    logic [PHASE_W-1:0]   raw;
    logic [PHASE_W-1:0]   cor;
  } phase_report_t;

  phase_report_t      phase_reports_q[$];
  logic [COUNT_W-1:0] lock_run [NUM_CHANNELS];
  logic [PHASE_W-1:0] raw_acc  [NUM_CHANNELS];
  logic [PHASE_W-1:0] cor_acc  [NUM_CHANNELS];
  logic               steering_on;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    checked_count = 0;
  end

  // pseudorange Q28.8 m to phase Q.16 cycles, round half up
  function automatic logic [PHASE_W-1:0] range_to_cycles(input logic [PR_W-1:0] pr);
    logic [127:0] p;
    p = 128'(pr) * 128'(L1_PER_C) + (128'd1 << 23);
    return p[24 +: PHASE_W];
  endfunction

  // rate * dt * L1/c, exact signed product, round half towards +inf
  function automatic logic [PHASE_W-1:0] drift_cycles(input logic signed [RATE_W-1:0] rate,
                                                      input logic [TIME_W-1:0] t_now,
                                                      input logic [TIME_W-1:0] t_prev);
    logic signed [TIME_W:0] dt;
    logic signed [127:0]    a;
    logic signed [127:0]    b;
    logic signed [127:0]    c;
    logic signed [127:0]    p;
    dt = $signed({1'b0, t_now}) - $signed({1'b0, t_prev});
    a  = rate;
    b  = dt;
    c  = $signed({64'd0, L1_PER_C});
    p  = a * b * c + (128'sd1 <<< 55);
    return p[56 +: PHASE_W];
  endfunction

  function automatic phase_report_t accumulate_epoch();
    phase_report_t             r;
    logic [CHANNEL_W-1:0]      ch;
    logic signed [PHASE_W-1:0] p_now;
    logic signed [PHASE_W-1:0] p_prev;
    logic [PHASE_W-1:0]        delta;
    logic [PHASE_W-1:0]        drift;
    ch     = in_mon.channel;
    r      = '0;
    r.ch   = ch;
    if (int'(ch) >= NUM_CHANNELS) begin
      return r;
    end
    p_now  = in_mon.phase_now;
    p_prev = in_mon.phase_prev;
    delta  = p_now - p_prev;
    drift  = drift_cycles(in_mon.clock_drift_rate, in_mon.rx_time_now, in_mon.rx_time_prev);
    if (!in_mon.measurement_valid) begin
      lock_run[ch] = '0;
    end else begin
      if (lock_run[ch] != COUNT_MAX) lock_run[ch] = lock_run[ch] + 1'b1;
      if (!steering_on) begin
        if (lock_run[ch] == SEED_COUNT_FREE) begin
          raw_acc[ch] = range_to_cycles(in_mon.raw_pseudorange);
          cor_acc[ch] = range_to_cycles(in_mon.corrected_pseudorange);
        end else begin
          raw_acc[ch] = raw_acc[ch] + delta;
          cor_acc[ch] = cor_acc[ch] + delta - drift;
        end
      end else begin
        if (lock_run[ch] == SEED_COUNT_STEERED) begin
          cor_acc[ch] = range_to_cycles(in_mon.raw_pseudorange);
        end else if (lock_run[ch] > SEED_COUNT_STEERED) begin
          cor_acc[ch] = cor_acc[ch] + delta - drift;
        end
      end
    end
    r.cnt = lock_run[ch];
    r.raw = raw_acc[ch];
    r.cor = cor_acc[ch];
    return r;
  endfunction

  function automatic void compare_field(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : monitor
    phase_report_t want;
    phase_report_t got;
    if (!rst_n) begin
      phase_reports_q.delete();
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        lock_run[i] = '0;
        raw_acc[i]  = '0;
        cor_acc[i]  = '0;
      end
      steering_on = 1'b0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) steering_on = cfg_mon.clock_steering;
      if (out_mon.valid && out_mon.ready) begin
        got.ch  = out_mon.out_channel;
        got.cnt = out_mon.lock_count;
        got.raw = out_mon.raw_carrier_phase;
        got.cor = out_mon.corrected_carrier_phase;
        if (phase_reports_q.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result transaction: expected none, got 0x%0h", $time, got);
        end else begin
          want = phase_reports_q.pop_front();
          compare_field("out_channel", 64'(want.ch), 64'(got.ch));
          compare_field("lock_count", 64'(want.cnt), 64'(got.cnt));
          compare_field("raw_carrier_phase", 64'(want.raw), 64'(got.raw));
          compare_field("corrected_carrier_phase", 64'(want.cor), 64'(got.cor));
          checked_count++;
        end
      end
      if (in_mon.valid && in_mon.ready) phase_reports_q.push_back(accumulate_epoch());
    end
    pending_count = phase_reports_q.size();
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cpca_pkg::*;

  localparam int LONG_HOLD   = 400;
  localparam int PHASE_ITEMS = 80;
  localparam int LOCK_RUN    = 270;

  localparam logic signed [PH_IN_W-1:0] PH_MAX   = {1'b0, {(PH_IN_W-1){1'b1}}};
  localparam logic signed [PH_IN_W-1:0] PH_MIN   = {1'b1, {(PH_IN_W-1){1'b0}}};
  localparam logic signed [RATE_W-1:0]  RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
  localparam logic signed [RATE_W-1:0]  RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

  typedef struct packed {
    logic [CHANNEL_W-1:0]      channel;
    logic                      meas_ok;
    logic [PR_W-1:0]           raw_pr;
    logic [PR_W-1:0]           cor_pr;
    logic signed [PH_IN_W-1:0] ph_now;
    logic signed [PH_IN_W-1:0] ph_prev;
    logic signed [RATE_W-1:0]  rate;
    logic [TIME_W-1:0]         t_now;
    logic [TIME_W-1:0]         t_prev;
  } epoch_t;

  logic clk = 1'b0;
  logic rst_n;

  int fail_count;
  int results_pending;
  int results_checked;
  int epochs_sent;
  int steer_writes;
  int src_idle_pct;
  int sink_idle_pct;
  bit long_hold_req;

  cpca_in_if  in_bus ();
  cpca_out_if out_bus ();
  cpca_cfg_if cfg_bus ();

  carrier_phase_correction_accumulator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  cpca_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .cfg_mon       (cfg_bus),
    .fail_count    (fail_count),
    .pending_count (results_pending),
    .checked_count (results_checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [63:0] pick_value(input int w);
    logic [63:0] m;
    m = (64'd1 << w) - 64'd1;
    case ($urandom_range(0, 11))
      0:       return 64'd0;
      1:       return m;
      2:       return 64'd1 << (w - 1);
      3:       return m >> 1;
      default: return {$urandom(), $urandom()} & m;
    endcase
  endfunction

  function automatic epoch_t random_epoch(input logic [CHANNEL_W-1:0] ch, input logic ok);
    epoch_t e;
    e.channel = ch;
    e.meas_ok = ok;
    e.raw_pr  = PR_W'(pick_value(PR_W));
    e.cor_pr  = PR_W'(pick_value(PR_W));
    e.ph_now  = PH_IN_W'(pick_value(PH_IN_W));
    e.ph_prev = PH_IN_W'(pick_value(PH_IN_W));
    e.rate    = RATE_W'(pick_value(RATE_W));
    e.t_now   = TIME_W'(pick_value(TIME_W));
    e.t_prev  = TIME_W'(pick_value(TIME_W));
    // plausible tracking: small phase step, bounded time step between epochs, small drift
    if ($urandom_range(0, 9) < 6) begin
      e.ph_now = e.ph_prev + PH_IN_W'($urandom_range(0, 1 << 21)) - PH_IN_W'(1 << 20);
      e.t_now  = e.t_prev + TIME_W'($urandom_range(0, 1 << 25));
      e.rate   = RATE_W'($urandom_range(0, 1 << 22)) - RATE_W'(1 << 21);
    end
    return e;
  endfunction

  task automatic send_epoch(input epoch_t e);
    @(negedge clk);
    if (src_idle_pct > 0 && $urandom_range(1, 100) <= src_idle_pct) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_bus.channel               = e.channel;
    in_bus.measurement_valid     = e.meas_ok;
    in_bus.raw_pseudorange       = e.raw_pr;
    in_bus.corrected_pseudorange = e.cor_pr;
    in_bus.phase_now             = e.ph_now;
    in_bus.phase_prev            = e.ph_prev;
    in_bus.clock_drift_rate      = e.rate;
    in_bus.rx_time_now           = e.t_now;
    in_bus.rx_time_prev          = e.t_prev;
    in_bus.valid                 = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    epochs_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    in_bus.valid = 1'b0;
    wait (results_pending == 0);
  endtask

  task automatic write_steering(input logic on);
    @(negedge clk);
    cfg_bus.clock_steering = on;
    cfg_bus.valid          = 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
    steer_writes++;
  endtask

  // result side back-pressure
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_bus.ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (sink_idle_pct > 0 && $urandom_range(1, 100) <= sink_idle_pct) begin
        out_bus.ready = 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        out_bus.ready = 1'b1;
      end
    end
  end

  initial begin
    epoch_t               e;
    logic [CHANNEL_W-1:0] ch;
    int                   n_items;

    epochs_sent   = 0;
    steer_writes  = 0;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    long_hold_req = 1'b0;
    rst_n         = 1'b0;
    in_bus.valid                 = 1'b0;
    in_bus.channel               = '0;
    in_bus.measurement_valid     = 1'b0;
    in_bus.raw_pseudorange       = '0;
    in_bus.corrected_pseudorange = '0;
    in_bus.phase_now             = '0;
    in_bus.phase_prev            = '0;
    in_bus.clock_drift_rate      = '0;
    in_bus.rx_time_now           = '0;
    in_bus.rx_time_prev          = '0;
    cfg_bus.valid                = 1'b0;
    cfg_bus.clock_steering       = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: steering off, extreme seeds and deltas
    e = random_epoch(3'd0, 1'b1);
    e.raw_pr = '1;
    e.cor_pr = '1;
    send_epoch(e);
    e = random_epoch(3'd0, 1'b1);
    e.ph_now  = PH_MAX;
    e.ph_prev = PH_MIN;
    e.rate    = RATE_MIN;
    e.t_now   = '1;
    e.t_prev  = '0;
    send_epoch(e);
    e = random_epoch(3'd0, 1'b1);
    e.ph_now  = PH_MIN;
    e.ph_prev = PH_MAX;
    e.rate    = RATE_MAX;
    e.t_now   = '0;
    e.t_prev  = '1;
    send_epoch(e);
    send_epoch(random_epoch(3'd0, 1'b0));
    e = random_epoch(3'd0, 1'b1);
    e.raw_pr = '0;
    e.cor_pr = '0;
    send_epoch(e);
    e = '0;
    e.channel = 3'd7;
    e.meas_ok = 1'b1;
    send_epoch(e);
    send_epoch(e);
    e.rate  = '1;
    e.t_now = TIME_W'(1);
    send_epoch(e);

    // steering on: channel 0 carries its count across, channel 1 starts afresh
    drain();
    write_steering(1'b1);
    for (int i = 0; i < 3; i++) send_epoch(random_epoch(3'd0, 1'b1));
    for (int i = 0; i < 5; i++) send_epoch(random_epoch(3'd1, 1'b1));
    send_epoch(random_epoch(3'd1, 1'b0));
    send_epoch(random_epoch(3'd1, 1'b1));
    drain();
    write_steering(1'b0);

    // random phases, channel runs with occasional dropouts
    ch = '0;
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      write_steering(1'($urandom_range(0, 1)));
      case ($urandom_range(0, 2))
        0:       begin src_idle_pct = 0;  sink_idle_pct = 0;  end
        1:       begin src_idle_pct = 25; sink_idle_pct = 3;  end
        default: begin src_idle_pct = 60; sink_idle_pct = 10; end
      endcase
      if (ph >= 8) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      if (ph == 2) long_hold_req = 1'b1;
      if (ph == 5) begin
        ch = CHANNEL_W'($urandom_range(0, NUM_CHANNELS - 1));
        for (int i = 0; i < LOCK_RUN; i++) send_epoch(random_epoch(ch, 1'b1));
        send_epoch(random_epoch(ch, 1'b0));
        send_epoch(random_epoch(ch, 1'b1));
      end else begin
        n_items = PHASE_ITEMS;
        for (int i = 0; i < n_items; i++) begin
          if ($urandom_range(0, 3) == 0) ch = CHANNEL_W'($urandom_range(0, 7));
          send_epoch(random_epoch(ch, $urandom_range(0, 19) != 0));
        end
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("summary: %0d epoch transactions sent, %0d results checked, %0d steering writes",
             epochs_sent, results_checked, steer_writes);
    $display("summary: lock count driven to saturation, dropouts, and a %0d-cycle result stall",
             LONG_HOLD);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
